// ===== design/uvg_pkg.sv =====
package uvg_pkg;

	// Field widths
	localparam int SEC_W     = 32;
	localparam int NS_W      = 30;
	localparam int CLK_SEQ_W = 14;
	localparam int TICKS_W   = 60;
	localparam int NODE_W    = 48;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRONTEND_MARK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_FOUND    = 2'd2;

	// Time constants
	localparam logic [NS_W-1:0] NS_MAX      = 30'd999999999;
	localparam logic [NS_W-1:0] NS_PER_SEC  = 30'd1000000000;
	localparam logic [NS_W-1:0] MIN_STEP_NS = 30'd100;

	// 100-ns ticks per second and the epoch offset of the UUID timestamp
	localparam logic [23:0]        TICKS_PER_SEC = 24'd10000000;
	localparam logic [TICKS_W-1:0] EPOCH_TICKS   = 60'd122192928000000000;

	// ns/100 = (ns>>2)/25, done as a reciprocal multiply: (x * DIV25_MUL) >> DIV25_SHIFT
	localparam int              DIV25_SHIFT = 33;
	localparam logic [28:0]     DIV25_MUL   = 29'd343597384;

	// Fixed UUID bits
	localparam logic [3:0] UUID_VERSION  = 4'h1;
	localparam logic [1:0] UUID_VARIANT  = 2'b10;

	// Two-entry queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One request after time and sequence are settled
	typedef struct packed {
		logic [SEC_W-1:0]     sec;
		logic [NS_W-1:0]      ns;
		logic [CLK_SEQ_W-1:0] seq_word;
	} job_t;

	// Configuration seen by the back end
	typedef struct packed {
		logic [NODE_W-1:0] node_address;
		logic              node_found;
	} back_cfg_t;

endpackage

// ===== design/uvg_if.sv =====
interface uvg_req_if;
	import uvg_pkg::*;
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] now_seconds;
	logic [NS_W-1:0]  now_nanoseconds;
	modport source(output valid, now_seconds, now_nanoseconds, input ready);
	modport sink(input valid, now_seconds, now_nanoseconds, output ready);
endinterface

interface uvg_uuid_if;
	import uvg_pkg::*;
	logic              valid;
	logic              ready;
	logic [31:0]       stamp_low;
	logic [15:0]       stamp_mid;
	logic [15:0]       time_hi_version;
	logic [7:0]        seq_hi_reserved;
	logic [7:0]        seq_low;
	logic [NODE_W-1:0] node_out;
	logic              local_only;
	modport source(output valid, stamp_low, stamp_mid, time_hi_version,
		seq_hi_reserved, seq_low, node_out, local_only, input ready);
	modport sink(input valid, stamp_low, stamp_mid, time_hi_version,
		seq_hi_reserved, seq_low, node_out, local_only, output ready);
endinterface

// ===== design/uvg_front.sv =====
module uvg_front #(
	parameter int SEQUENCE_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	uvg_req_if.sink       req,
	input  logic          frontend_mark,
	output uvg_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_ready
);
	import uvg_pkg::*;

	logic [SEC_W-1:0]         last_sec_q;
	logic [NS_W-1:0]          last_ns_q;
	logic [SEQUENCE_BITS-1:0] seq_count_q;

	logic [NS_W-1:0]          ns_sat;
	logic [NS_W-1:0]          last_plus;
	logic                     bump;
	logic [SEC_W-1:0]         sec_use;
	logic [NS_W-1:0]          ns_use;
	logic [SEQUENCE_BITS-1:0] seq_next;
	logic [CLK_SEQ_W-1:0]     seq_word;
	logic                     xfer;

	assign req.ready = job_ready;
	assign job_valid = req.valid;
	assign xfer      = req.valid & job_ready;

	// Saturate nanoseconds, then force forward motion: at least 100 ns within the same second, else a later second
	always_comb begin
		ns_sat    = (req.now_nanoseconds > NS_MAX) ? NS_MAX : req.now_nanoseconds;
		last_plus = last_ns_q + MIN_STEP_NS;
		bump      = (req.now_seconds < last_sec_q) ||
			((req.now_seconds == last_sec_q) && (ns_sat < last_plus));
		sec_use   = req.now_seconds;
		ns_use    = ns_sat;
		if (bump) begin
			if (last_plus >= NS_PER_SEC) begin
				sec_use = last_sec_q + SEC_W'(1);
				ns_use  = '0;
			end else begin
				sec_use = last_sec_q;
				ns_use  = last_plus;
			end
		end
	end

	// Wrapping sequence counter with optional front-end mark
	always_comb begin
		seq_next = (seq_count_q == {SEQUENCE_BITS{1'b1}}) ? '0 :
			seq_count_q + SEQUENCE_BITS'(1);
		seq_word = CLK_SEQ_W'(seq_next);
		if (frontend_mark) begin
			seq_word[SEQUENCE_BITS] = 1'b1;
		end
	end

	assign job.sec      = sec_use;
	assign job.ns       = ns_use;
	assign job.seq_word = seq_word;

	// State advances on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sec_q  <= '0;
			last_ns_q   <= '0;
			seq_count_q <= '0;
		end else if (xfer) begin
			last_sec_q  <= sec_use;
			last_ns_q   <= ns_use;
			seq_count_q <= seq_next;
		end
	end

endmodule

// ===== design/uvg_queue.sv =====
module uvg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  uvg_pkg::job_t push_data,
	input  logic          push_valid,
	output logic          push_ready,
	output uvg_pkg::job_t pop_data,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import uvg_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_ready & pop_valid;
	assign pop_data   = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/uvg_back.sv =====
module uvg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  uvg_pkg::job_t     job,
	input  logic              job_valid,
	output logic              job_ready,
	input  uvg_pkg::back_cfg_t cfg,
	uvg_uuid_if.source        rsp
);
	import uvg_pkg::*;

	// Stage 1: products
	logic                 valid_s1;
	logic [55:0]          sec_ticks_s1;
	logic [56:0]          ns_prod_s1;
	logic [CLK_SEQ_W-1:0] seq_word_s1;

	// Stage 2: packed UUID fields
	logic                 valid_s2;
	logic [31:0]          stamp_low_s2;
	logic [15:0]          stamp_mid_s2;
	logic [15:0]          time_hi_s2;
	logic [7:0]           seq_hi_s2;
	logic [7:0]           seq_low_s2;
	logic [NODE_W-1:0]    node_s2;
	logic                 local_only_s2;

	logic                 ready_s1;
	logic                 ready_s2;
	logic [TICKS_W-1:0]   ticks;
	logic [23:0]          ns_ticks;

	assign ready_s2  = !valid_s2 | rsp.ready;
	assign ready_s1  = !valid_s1 | ready_s2;
	assign job_ready = ready_s1;

	// Timestamp sum: seconds part, ns/100 and epoch offset
	assign ns_ticks = ns_prod_s1[DIV25_SHIFT +: 24];
	assign ticks    = TICKS_W'(sec_ticks_s1) + TICKS_W'(ns_ticks) + EPOCH_TICKS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= job_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (ready_s1 && job_valid) begin
			sec_ticks_s1 <= job.sec * TICKS_PER_SEC;
			ns_prod_s1   <= job.ns[NS_W-1:2] * DIV25_MUL;
			seq_word_s1  <= job.seq_word;
		end
	end

	// Add and pack stage
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			stamp_low_s2  <= ticks[31:0];
			stamp_mid_s2  <= ticks[47:32];
			time_hi_s2    <= {UUID_VERSION, ticks[59:48]};
			seq_hi_s2     <= {UUID_VARIANT, seq_word_s1[13:8]};
			seq_low_s2    <= seq_word_s1[7:0];
			node_s2       <= cfg.node_address;
			local_only_s2 <= !cfg.node_found;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.stamp_low       = stamp_low_s2;
	assign rsp.stamp_mid       = stamp_mid_s2;
	assign rsp.time_hi_version = time_hi_s2;
	assign rsp.seq_hi_reserved = seq_hi_s2;
	assign rsp.seq_low         = seq_low_s2;
	assign rsp.node_out        = node_s2;
	assign rsp.local_only      = local_only_s2;

endmodule

// ===== design/uuid_v1_generator.sv =====
// Time-based (version 1) UUID generator.
// req: one transfer per UUID request, carrying seconds since 1970 and
//   nanoseconds. The front end saturates nanoseconds, keeps time moving
//   forward (at least 100 ns within a second, else to a later second) and
//   steps the clock sequence, all in the cycle of the transfer.
// A two-entry queue sits between the front end and the timestamp unit.
// rsp: one transfer per request, in request order, with the packed UUID
//   fields, the configured node and the local-only flag.
// Path: a req transfer passes the queue, the multiply stage and the
//   add-and-pack output register before rsp.valid rises. Throughput: one
//   request per cycle while rsp.ready stays high; the front end, the queue
//   and the two back-end stages each take one item per cycle.
// Stalls: when rsp.ready is low the output register holds, the back end
//   fills, the queue fills, then req.ready drops. No item is lost.
// Configuration: cfg_we writes register cfg_index (0 node address,
//   1 front-end mark, 2 node found); other indexes are ignored.
// Reset: last time and sequence clear to 0, node address 0, front-end
//   mark 1, node found 0; all pipeline stages empty.
module uuid_v1_generator #(
	parameter int SEQUENCE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	uvg_req_if.sink                       req,
	uvg_uuid_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [uvg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uvg_pkg::NODE_W-1:0]    cfg_data
);
	import uvg_pkg::*;

	logic [NODE_W-1:0] node_address_q;
	logic              frontend_mark_q;
	logic              node_found_q;

	job_t      front_job;
	logic      front_valid;
	logic      front_ready;
	job_t      back_job;
	logic      back_valid;
	logic      back_ready;
	back_cfg_t back_cfg;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q  <= '0;
			frontend_mark_q <= 1'b1;
			node_found_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_ADDRESS:  node_address_q  <= cfg_data;
				CFG_FRONTEND_MARK: frontend_mark_q <= cfg_data[0];
				CFG_NODE_FOUND:    node_found_q    <= cfg_data[0];
				default:           node_address_q  <= node_address_q;
			endcase
		end
	end

	assign back_cfg.node_address = node_address_q;
	assign back_cfg.node_found   = node_found_q;

	uvg_front #(
		.SEQUENCE_BITS(SEQUENCE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.frontend_mark(frontend_mark_q),
		.job          (front_job),
		.job_valid    (front_valid),
		.job_ready    (front_ready)
	);

	uvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (front_job),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.pop_data  (back_job),
		.pop_valid (back_valid),
		.pop_ready (back_ready)
	);

	uvg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (back_job),
		.job_valid(back_valid),
		.job_ready(back_ready),
		.cfg      (back_cfg),
		.rsp      (rsp)
	);

endmodule
